[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the emitter pool
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while reset is low
`define PSEP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on aclk, disabled while aresetn is low
`define PSEP_ASSERT(lbl, prop, msg) \
    `PSEP_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

[sv/psep_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psep_pkg
// Types, codes and helpers shared by the emitter pool modules.
// ----------------------------------------------------------------------------
package psep_pkg;

    localparam int POOL_SIZE_DEF  = 64;
    localparam int MAX_SPAWNS_DEF = 32;

    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 104;

    // Command codes
    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_KILL   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_CREATED = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_SPAWN   = 2'd2;
    localparam logic [1:0] KIND_ACK     = 2'd3;

    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    // Per-slot record held in the record memory
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] dcred;
        logic [31:0] tcred;
        logic [31:0] spacing;
        logic [31:0] interval;
        logic [31:0] jscale;
    } rec_t;

    typedef struct packed {
        logic active;
        logic emitting;
    } flag_t;

    typedef struct packed {
        logic  flag_we;
        flag_t flag_wd;
        logic  rec_we;
    } store_wr_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_SRCH_RD, ST_SRCH_CHK, ST_CRT_DIV, ST_CRT_WR,
        ST_RD, ST_DEC, ST_DIFF, ST_SQ, ST_ACC, ST_SQRT, ST_CNT_DIV, ST_CRED,
        ST_JS_DIV, ST_INT_DIV, ST_STEP, ST_J_LFSR, ST_J_MOD, ST_J_R, ST_J_MUL,
        ST_J_OFF, ST_J_SUM, ST_EMIT
    } state_t;

    // Galois LFSR, one shift to the right
    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        return v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
    endfunction

    // Fold a word by bytes into a value congruent mod 201 (below 54571)
    function automatic logic [15:0] fold201(input logic [31:0] v);
        return 16'(v[31:24]) * 16'd148 + 16'(v[23:16]) * 16'd10
             + 16'(v[15:8]) * 16'd55 + 16'(v[7:0]);
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[sv/psep_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psep_div
// Restoring unsigned divider, 33-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module psep_div import psep_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [32:0] quot,
    output logic [31:0] rem
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;
    logic        ge;

    // Trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quot_reg[32]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            quot_next = {quot_reg[31:0], ge};
            cnt_next  = cnt_reg + 6'd1;
            if (cnt_reg == 6'd32) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

[sv/psep_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psep_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module psep_sqrt import psep_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] rb;

    assign rb = res_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = radicand;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            // Take one digit pair
            if (v_reg >= rb) begin
                v_next   = v_reg - rb;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

[sv/psep_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psep_store
// Slot flag memory and slot record memory, one shared address, registered
// read data.
// ----------------------------------------------------------------------------
module psep_store import psep_pkg::*; #(
    parameter int POOL_SIZE = POOL_SIZE_DEF,
    parameter int IDX_W     = 6
) (
    input  logic             aclk,
    input  logic [IDX_W-1:0] addr,
    input  store_wr_t        wr,
    input  rec_t             rec_wd,
    output flag_t            flag_rd,
    output rec_t             rec_rd
);

    flag_t flag_mem [POOL_SIZE];
    rec_t  rec_mem  [POOL_SIZE];

    // Flag memory: write and registered read
    always_ff @(posedge aclk) begin
        if (wr.flag_we) begin
            flag_mem[addr] <= wr.flag_wd;
        end
        flag_rd <= flag_mem[addr];
    end

    // Record memory: write and registered read
    always_ff @(posedge aclk) begin
        if (wr.rec_we) begin
            rec_mem[addr] <= rec_wd;
        end
        rec_rd <= rec_mem[addr];
    end

endmodule

[sv/path_spaced_particle_emitter_pool.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// path_spaced_particle_emitter_pool
// Emitter pool: create, update, stop and kill commands; updates emit
// jittered spawn positions spaced along the path or paced by time.
//
//   channel   | direction | carries
//   s_        | in        | command word (tuser cmd, tdata id/pos/params)
//   m_        | out       | result word (tuser kind, tdata slot/pos, tlast)
//   cfg_      | in        | jitter LFSR seed
//
// Reset runs a clearing pass over the flag memory, with s_tready low.
// One command word is handled at a time.
// Create: one read and check per scanned slot, plus a divide when a rate
// needs it. Update: the distance square root in spacing mode, the spawn
// count divide, the jitter scale, one setup divide per axis in spacing mode
// and then the jitter steps for each spawn.
// A stalled m_tready holds the sequencer in its result step.
// ----------------------------------------------------------------------------
module path_spaced_particle_emitter_pool import psep_pkg::*; #(
    parameter int POOL_SIZE  = POOL_SIZE_DEF,
    parameter int MAX_SPAWNS = MAX_SPAWNS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // emitter_id, pos_x, pos_y, pos_z, time_step, spawn_spacing,
    // spawn_rate, jitter_scale, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // slot, spawn_x, spawn_y, spawn_z, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // kind
    output logic [1:0]             m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [31:0]            cfg_data
);

    localparam int IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W  = $clog2(MAX_SPAWNS + 1);
    localparam int SCAN_W = $clog2(POOL_SIZE + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(POOL_SIZE - 1);
    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(POOL_SIZE);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_SPAWNS);

    state_t state_reg, state_next;

    // Control registers
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  search_reg;
    logic [31:0]       lfsr_reg;
    logic              div_pend_reg, sq_pend_reg;
    logic              m_tvalid_reg;

    // Command word
    logic [1:0]  cmd_reg;
    logic [5:0]  id_reg;
    logic [31:0] n_reg [3];
    logic [31:0] dt_reg, spc_reg, rate_reg, js_reg;

    // Update working set
    logic [31:0]      o_reg [3];
    rec_t             rec_w_reg;
    logic             mode_dist_reg;
    logic [31:0]      cred_reg, base_reg, credrem_reg;
    logic             capped_reg;
    logic [CNT_W-1:0] count_reg, idx_reg;
    logic [31:0]      mag_reg [3];
    logic             neg_reg [3];
    logic [63:0]      prod_reg, sum_reg;
    logic             ovf_reg;
    logic [1:0]       ax_reg;
    logic [31:0]      qd_reg [3], accq_reg [3];
    logic [CNT_W-1:0] rd_reg [3], accr_reg [3];
    logic [31:0]      bpos_reg [3], sp_reg [3];

    // Jitter pipeline
    logic [31:0] ja_reg;
    logic [6:0]  jb_reg;
    logic [15:0] y_reg;
    logic [8:0]  q201_reg;
    logic        rneg_reg;
    logic [6:0]  rmag_reg;
    logic [38:0] pa_reg;
    logic [13:0] pb_reg;
    logic [32:0] off_reg;

    // Pending result
    logic [1:0] pend_kind_reg;
    logic [5:0] pend_slot_reg;
    logic       pend_last_reg;

    // Output register
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]             m_tuser_reg;
    logic                   m_tlast_reg;

    // Units and memory
    logic        div_start, div_done;
    logic [32:0] div_dvd, div_quot;
    logic [31:0] div_dvs, div_rem;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    store_wr_t   store_wr;
    rec_t        rec_wd, rec_rd;
    flag_t       flag_rd;

    logic s_acc, out_free, in_range_in;
    logic [SCAN_W-1:0] scan_reg;
    logic [IDX_W-1:0]  addr_inc;
    rec_t              rec_upd;
    logic [31:0]       cred_new;

    assign s_acc       = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign in_range_in = 32'(s_tdata[5:0]) < 32'(POOL_SIZE);
    assign addr_inc    = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;

    // Record with the new position written in
    always_comb begin
        rec_upd    = rec_rd;
        rec_upd.px = n_reg[0];
        rec_upd.py = n_reg[1];
        rec_upd.pz = n_reg[2];
    end

    // Credit left after the spawns are paid for
    assign cred_new = capped_reg ? 32'(cred_reg - 39'(MAX_CNT) * base_reg) : credrem_reg;

    // Divider operand select
    always_comb begin
        div_dvd = {1'b0, cred_reg};
        div_dvs = base_reg;
        unique case (state_reg)
            ST_CRT_DIV: begin
                div_dvd = 33'h1_0000_0000;
                div_dvs = rate_reg;
            end
            ST_INT_DIV: begin
                div_dvd = {1'b0, mag_reg[ax_reg]};
                div_dvs = 32'(count_reg);
            end
            default: begin
            end
        endcase
    end

    psep_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    psep_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    psep_store #(
        .POOL_SIZE (POOL_SIZE),
        .IDX_W     (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .addr    (addr_reg),
        .wr      (store_wr),
        .rec_wd  (rec_wd),
        .flag_rd (flag_rd),
        .rec_rd  (rec_rd)
    );

    // Sequencer: next state, unit starts and memory writes
    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        div_start  = 1'b0;
        sq_start   = 1'b0;
        store_wr   = '0;
        rec_wd     = rec_w_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                store_wr.flag_we = 1'b1;
                addr_next        = addr_inc;
                if (addr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == CMD_CREATE) begin
                        addr_next  = search_reg;
                        state_next = ST_SRCH_RD;
                    end else if (in_range_in) begin
                        addr_next  = IDX_W'(s_tdata[5:0]);
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SRCH_RD: state_next = ST_SRCH_CHK;
            ST_SRCH_CHK: begin
                if (!flag_rd.active) begin
                    state_next = (rate_reg > 32'd1) ? ST_CRT_DIV : ST_CRT_WR;
                end else if (scan_reg + 1'b1 == SCAN_END) begin
                    state_next = ST_EMIT;
                end else begin
                    addr_next  = addr_inc;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_CRT_DIV: begin
                div_start = !div_pend_reg;
                if (div_done) begin
                    state_next = ST_CRT_WR;
                end
            end
            ST_CRT_WR: begin
                store_wr.flag_we = 1'b1;
                store_wr.flag_wd = '{active: 1'b1, emitting: 1'b1};
                store_wr.rec_we  = 1'b1;
                rec_wd = '{px: n_reg[0], py: n_reg[1], pz: n_reg[2], dcred: 32'd0,
                           tcred: 32'd0, spacing: spc_reg, interval: base_reg,
                           jscale: js_reg};
                state_next = ST_EMIT;
            end
            ST_RD: state_next = ST_DEC;
            ST_DEC: begin
                state_next = ST_EMIT;
                unique case (cmd_reg)
                    CMD_STOP: begin
                        store_wr.flag_we = 1'b1;
                        store_wr.flag_wd = '{active: flag_rd.active, emitting: 1'b0};
                    end
                    CMD_KILL: begin
                        store_wr.flag_we = 1'b1;
                        store_wr.flag_wd = '{active: 1'b0, emitting: flag_rd.emitting};
                    end
                    CMD_UPDATE: begin
                        if (flag_rd.active) begin
                            store_wr.rec_we = 1'b1;
                            rec_wd          = rec_upd;
                            if (flag_rd.emitting) begin
                                if (rec_rd.spacing != '0) begin
                                    state_next = ST_DIFF;
                                end else if (rec_rd.interval != '0) begin
                                    state_next = ST_CNT_DIV;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_DIFF: state_next = ST_SQ;
            ST_SQ:   state_next = ST_ACC;
            ST_ACC:  state_next = (ax_reg == 2'd2) ? ST_SQRT : ST_SQ;
            ST_SQRT: begin
                sq_start = !sq_pend_reg;
                if (sq_done) begin
                    state_next = ST_CNT_DIV;
                end
            end
            ST_CNT_DIV: begin
                div_start = !div_pend_reg;
                if (div_done) begin
                    state_next = ST_CRED;
                end
            end
            ST_CRED: begin
                store_wr.rec_we = 1'b1;
                rec_wd          = rec_w_reg;
                if (mode_dist_reg) begin
                    rec_wd.dcred = cred_new;
                end else begin
                    rec_wd.tcred = cred_new;
                end
                state_next = (count_reg == '0) ? ST_EMIT : ST_JS_DIV;
            end
            ST_JS_DIV: state_next = mode_dist_reg ? ST_INT_DIV : ST_STEP;
            ST_INT_DIV: begin
                div_start = !div_pend_reg;
                if (div_done && ax_reg == 2'd2) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:   state_next = ST_J_LFSR;
            ST_J_LFSR: state_next = ST_J_MOD;
            ST_J_MOD:  state_next = ST_J_R;
            ST_J_R:    state_next = ST_J_MUL;
            ST_J_MUL:  state_next = ST_J_OFF;
            ST_J_OFF:  state_next = ST_J_SUM;
            ST_J_SUM:  state_next = (ax_reg == 2'd2) ? ST_EMIT : ST_J_LFSR;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = pend_last_reg ? ST_IDLE : ST_STEP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            search_reg   <= '0;
            lfsr_reg     <= 32'd1;
            div_pend_reg <= 1'b0;
            sq_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            // Advance the next-fit start past a claimed slot
            if (state_reg == ST_CRT_WR) begin
                search_reg <= addr_inc;
            end
            // Seed load, else step once per axis
            if (cfg_valid && cfg_ready) begin
                lfsr_reg <= (cfg_data != '0) ? cfg_data : 32'd1;
            end else if (state_reg == ST_J_LFSR) begin
                lfsr_reg <= lfsr_step(lfsr_reg);
            end
            if (div_start) begin
                div_pend_reg <= 1'b1;
            end else if (div_done) begin
                div_pend_reg <= 1'b0;
            end
            if (sq_start) begin
                sq_pend_reg <= 1'b1;
            end else if (sq_done) begin
                sq_pend_reg <= 1'b0;
            end
            // Output word valid
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cmd_reg       <= s_tuser;
                id_reg        <= s_tdata[5:0];
                n_reg[0]      <= s_tdata[37:6];
                n_reg[1]      <= s_tdata[69:38];
                n_reg[2]      <= s_tdata[101:70];
                dt_reg        <= s_tdata[133:102];
                spc_reg       <= s_tdata[165:134];
                rate_reg      <= s_tdata[197:166];
                js_reg        <= s_tdata[229:198];
                scan_reg      <= '0;
                pend_kind_reg <= KIND_ACK;
                pend_slot_reg <= s_tdata[5:0];
                pend_last_reg <= 1'b1;
            end
            ST_SRCH_CHK: begin
                scan_reg <= scan_reg + 1'b1;
                base_reg <= (rate_reg == '0) ? 32'd0 : 32'hFFFF_FFFF;
                if (flag_rd.active) begin
                    pend_kind_reg <= KIND_FULL;
                    pend_slot_reg <= '0;
                end
            end
            ST_CRT_DIV: begin
                if (div_done) begin
                    base_reg <= div_quot[31:0];
                end
            end
            ST_CRT_WR: begin
                pend_kind_reg <= KIND_CREATED;
                pend_slot_reg <= 6'(addr_reg);
            end
            ST_DEC: begin
                o_reg[0]      <= rec_rd.px;
                o_reg[1]      <= rec_rd.py;
                o_reg[2]      <= rec_rd.pz;
                rec_w_reg     <= rec_upd;
                ja_reg        <= '0;
                mode_dist_reg <= rec_rd.spacing != '0;
                if (rec_rd.spacing != '0) begin
                    base_reg <= rec_rd.spacing;
                    cred_reg <= rec_rd.dcred;
                end else begin
                    base_reg <= rec_rd.interval;
                    cred_reg <= add_sat(rec_rd.tcred, dt_reg);
                end
                js_reg <= rec_rd.jscale;
            end
            ST_DIFF: begin
                // Per-axis magnitude and sign of the travelled segment
                for (int k = 0; k < 3; k++) begin
                    logic [32:0] d;
                    d = {n_reg[k][31], n_reg[k]} - {o_reg[k][31], o_reg[k]};
                    neg_reg[k] <= d[32];
                    mag_reg[k] <= d[32] ? 32'(-d) : d[31:0];
                end
                sum_reg <= '0;
                ovf_reg <= 1'b0;
                ax_reg  <= '0;
            end
            ST_SQ: prod_reg <= 64'(mag_reg[ax_reg]) * 64'(mag_reg[ax_reg]);
            ST_ACC: begin
                logic [64:0] s;
                s = {1'b0, sum_reg} + {1'b0, prod_reg};
                sum_reg <= s[63:0];
                ovf_reg <= ovf_reg | s[64];
                ax_reg  <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
            end
            ST_SQRT: begin
                if (sq_done) begin
                    cred_reg <= add_sat(cred_reg, ovf_reg ? 32'hFFFF_FFFF : sq_root);
                end
            end
            ST_CNT_DIV: begin
                if (div_done) begin
                    capped_reg  <= div_quot > 33'(MAX_CNT);
                    count_reg   <= (div_quot > 33'(MAX_CNT)) ? MAX_CNT
                                                              : div_quot[CNT_W-1:0];
                    credrem_reg <= div_rem;
                end
            end
            ST_CRED: begin
                idx_reg <= '0;
                ax_reg  <= '0;
            end
            ST_JS_DIV: begin
                // Scale by 1/100 with a reciprocal multiply, exact for 32-bit words
                logic [63:0] p;
                p = 64'(js_reg) * 64'(32'h51EB_851F);
                ja_reg <= 32'(p[63:37]);
            end
            ST_INT_DIV: begin
                if (div_done) begin
                    qd_reg[ax_reg]   <= div_quot[31:0];
                    rd_reg[ax_reg]   <= div_rem[CNT_W-1:0];
                    accq_reg[ax_reg] <= '0;
                    accr_reg[ax_reg] <= '0;
                    ax_reg           <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
            end
            ST_STEP: begin
                // Advance the interpolation point by one spawn
                idx_reg <= idx_reg + 1'b1;
                ax_reg  <= '0;
                jb_reg  <= 7'(js_reg - ja_reg * 32'd100);
                for (int k = 0; k < 3; k++) begin
                    logic [CNT_W:0] nr;
                    logic [31:0]    nq;
                    nr = {1'b0, accr_reg[k]} + {1'b0, rd_reg[k]};
                    nq = accq_reg[k] + qd_reg[k];
                    if (nr >= {1'b0, count_reg}) begin
                        nr = nr - {1'b0, count_reg};
                        nq = nq + 32'd1;
                    end
                    accr_reg[k] <= nr[CNT_W-1:0];
                    accq_reg[k] <= nq;
                    if (mode_dist_reg) begin
                        bpos_reg[k] <= neg_reg[k] ? o_reg[k] - nq : o_reg[k] + nq;
                    end else begin
                        bpos_reg[k] <= n_reg[k];
                    end
                end
            end
            ST_J_LFSR: y_reg <= fold201(lfsr_step(lfsr_reg));
            ST_J_MOD: begin
                logic [39:0] p;
                p = 40'(y_reg) * 40'd10683999;
                q201_reg <= p[39:31];
            end
            ST_J_R: begin
                logic [7:0] m;
                m = 8'(y_reg - 16'(q201_reg) * 16'd201);
                rneg_reg <= m < 8'd100;
                rmag_reg <= (m < 8'd100) ? 7'(8'd100 - m) : 7'(m - 8'd100);
            end
            ST_J_MUL: begin
                pa_reg <= 39'(rmag_reg) * 39'(ja_reg);
                pb_reg <= 14'(rmag_reg) * 14'(jb_reg);
            end
            ST_J_OFF: begin
                logic [26:0] t;
                t = 27'(pb_reg) * 27'd5243;
                off_reg <= pa_reg[32:0] + 33'(t[26:19]);
            end
            ST_J_SUM: begin
                // Add the offset and clamp to the signed word range
                logic [33:0] b, s;
                b = {{2{bpos_reg[ax_reg][31]}}, bpos_reg[ax_reg]};
                s = rneg_reg ? b - {1'b0, off_reg} : b + {1'b0, off_reg};
                if (!s[33] && s[32:31] != 2'b00) begin
                    sp_reg[ax_reg] <= 32'h7FFF_FFFF;
                end else if (s[33] && s[32:31] != 2'b11) begin
                    sp_reg[ax_reg] <= 32'h8000_0000;
                end else begin
                    sp_reg[ax_reg] <= s[31:0];
                end
                ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                if (ax_reg == 2'd2) begin
                    pend_kind_reg <= KIND_SPAWN;
                    pend_slot_reg <= id_reg;
                    pend_last_reg <= idx_reg == count_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_tuser_reg <= pend_kind_reg;
            m_tlast_reg <= pend_last_reg;
            if (pend_kind_reg == KIND_SPAWN) begin
                m_tdata_reg <= {2'b00, sp_reg[2], sp_reg[1], sp_reg[0], pend_slot_reg};
            end else begin
                m_tdata_reg <= {98'd0, pend_slot_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `PSEP_ASSERT(a_count_cap, (state_reg == ST_STEP) |-> (count_reg != '0 && count_reg <= MAX_CNT), "spawn count out of range")
    `PSEP_ASSERT(a_emit_hold, (state_reg == ST_EMIT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_EMIT), "result step left while output held")
    `PSEP_ASSERT(a_idx_bound, (state_reg == ST_J_SUM) |-> (idx_reg != '0 && idx_reg <= count_reg), "spawn index beyond count")
    `PSEP_ASSERT(a_lfsr_live, (state_reg != ST_CLEAR) |-> (lfsr_reg != '0), "jitter LFSR reached zero")

endmodule
